/* rtl/core/rme_pkg.sv */
package rme_pkg;

  localparam int unsigned NumRegsDef   = 64;
  localparam int unsigned VecLenDef    = 16;
  localparam int unsigned ProgDepthDef = 1024;

  localparam int unsigned WordW = 32;
  localparam int unsigned LineW = 10;

  typedef enum logic [3:0] {
    OP_READ  = 4'd0,
    OP_WRITE = 4'd1,
    OP_LOAD  = 4'd2,
    OP_STORE = 4'd3,
    OP_ADD   = 4'd4,
    OP_SUB   = 4'd5,
    OP_MUL   = 4'd6,
    OP_DIV   = 4'd7,
    OP_JUMP  = 4'd8,
    OP_JZERO = 4'd9,
    OP_JGTZ  = 4'd10,
    OP_HALT  = 4'd11
  } op_e;

  typedef enum logic [1:0] {
    MODE_INDIRECT = 2'd0,
    MODE_DIRECT   = 2'd1,
    MODE_IMM      = 2'd2,
    MODE_VECTOR   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_REGZERO = 3'd1,
    ERR_MODE    = 3'd2,
    ERR_RANGE   = 3'd3,
    ERR_DIVZERO = 3'd4,
    ERR_TAG     = 3'd5
  } err_e;

  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/ram_machine_execute.sv */
// Steps: ST_IDX, ST_PTR, ST_ADDR, ST_VAL, ST_EXEC, ST_OUT, doing up to three dependent
// reads of the one-read, one-write-port register file plus one write; a stopped machine
// or fault skips to ST_OUT; div waits on the radix-2 divider; results wait for tready.
// Throughput: one instruction at a time; tready is low while one is in flight.
// Reset: after reset a clearing pass writes every register file word to zero,
// all NUM_REGS*VEC_LEN of them, before the first transaction is taken.
module ram_machine_execute
  import rme_pkg::*;
#(
  parameter int unsigned NUM_REGS   = NumRegsDef,
  parameter int unsigned VEC_LEN    = VecLenDef,
  parameter int unsigned PROG_DEPTH = ProgDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // req_type[3:0], mode[5:4], operand[37:6], elem_index[41:38], index_from_reg[42],
  // index_reg[48:43], tape_in[80:49], jump_target[90:81], target_found[91], zero[95:92]
  input  logic [95:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tape_out_valid[0], tape_out[32:1], next_line[42:33], halted[43],
  // error_code[46:44], zero[47]
  output logic [47:0] m_axis_tdata_o
);

  localparam int unsigned Words = NUM_REGS * VEC_LEN;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned RegW  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned VecW  = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_IDX, ST_PTR, ST_ADDR, ST_VAL, ST_EXEC, ST_DIV, ST_OUT
  } state_e;

  logic [WordW-1:0] mem [Words];
  logic [WordW-1:0] rdata_q;
  logic [AddrW-1:0] raddr, waddr;
  logic             we;
  logic [WordW-1:0] wdata;

  state_e           state_q;
  logic [AddrW:0]   clr_q;
  logic [95:0]      item_q;
  logic [WordW-1:0] acc_q, val_q;
  logic [AddrW-1:0] addr_q;
  logic [VecW-1:0]  pos_q;
  logic [LineW-1:0] pc_q;
  logic             halt_q, err_q;
  logic [47:0]      out_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [3:0]       i_op;
  logic [1:0]       i_mode;
  logic [WordW-1:0] i_opnd, i_tape;
  logic [3:0]       i_elem;
  logic             i_ifr, i_found;
  logic [5:0]       i_ireg;
  logic [LineW-1:0] i_tgt, nxt_line;

  assign i_op    = item_q[3:0];
  assign i_mode  = item_q[5:4];
  assign i_opnd  = item_q[37:6];
  assign i_elem  = item_q[41:38];
  assign i_ifr   = item_q[42];
  assign i_ireg  = item_q[48:43];
  assign i_tape  = item_q[80:49];
  assign i_tgt   = item_q[90:81];
  assign i_found = item_q[91];
  assign nxt_line = (32'(pc_q) + 32'd1 >= 32'(PROG_DEPTH)) ? '0 : pc_q + 1'b1;

  function automatic logic reg_ok(logic [WordW-1:0] r);
    return r < WordW'(NUM_REGS);
  endfunction

  function automatic logic [AddrW-1:0] word_addr(logic [WordW-1:0] r, logic [VecW-1:0] e);
    return AddrW'(32'(r[RegW-1:0]) * 32'(VEC_LEN) + 32'(e));
  endfunction

  function automatic logic is_locate(logic [3:0] op);
    return op == OP_READ || op == OP_STORE;
  endfunction

  // Register file: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  rme_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  state_e           state_d;
  logic [AddrW:0]   clr_d;
  logic [95:0]      item_d;
  logic [WordW-1:0] acc_d, val_d;
  logic [AddrW-1:0] addr_d;
  logic [VecW-1:0]  pos_d;
  logic [LineW-1:0] pc_d;
  logic             halt_d, err_d;
  logic [47:0]      out_d;
  logic [2:0]       ecode;
  logic             take;
  logic [63:0]      prod;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    item_d  = item_q;
    acc_d   = acc_q;
    val_d   = val_q;
    addr_d  = addr_q;
    pos_d   = pos_q;
    pc_d    = pc_q;
    halt_d  = halt_q;
    err_d   = err_q;
    out_d   = out_q;
    raddr   = '0;
    waddr   = addr_q;
    we      = 1'b0;
    wdata   = '0;
    ecode   = ERR_NONE;
    take    = 1'b0;
    prod    = 64'(acc_q) * 64'(val_q);
    div_req = '{start: 1'b0, dividend: acc_q, divisor: val_q};
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q[AddrW-1:0];
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == 32'(Words - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        raddr = '0;
        if (s_axis_tvalid_i) begin
          item_d  = s_axis_tdata_i;
          state_d = ST_IDX;
        end
      end
      ST_IDX: begin
        // acc read done in idle; fetch index register element 0
        acc_d = rdata_q;
        raddr = word_addr(32'(i_ireg), '0);
        if (halt_q || err_q) begin
          out_d   = {1'b0, 3'(ERR_NONE), halt_q, pc_q, 32'd0, 1'b0};
          state_d = ST_OUT;
        end else begin
          state_d = ST_PTR;
        end
      end
      ST_PTR: begin
        // resolve element position and first address
        if (i_mode == MODE_VECTOR) begin
          if (i_ifr) begin
            if (32'(i_ireg) >= 32'(NUM_REGS) || $signed(rdata_q) < 0
                || rdata_q >= WordW'(VEC_LEN)) ecode = ERR_RANGE;
            pos_d = VecW'(rdata_q);
          end else begin
            if (32'(i_elem) >= 32'(VEC_LEN)) ecode = ERR_RANGE;
            pos_d = VecW'(i_elem);
          end
        end else begin
          pos_d = '0;
        end
        if ((i_op == OP_READ && i_mode == MODE_IMM) || (i_op == OP_STORE && i_mode == MODE_IMM))
          ecode = ERR_MODE;
        else if ((i_op == OP_READ || i_op == OP_WRITE) && i_opnd == '0)
          ecode = ERR_REGZERO;
        else if (i_op <= OP_DIV && i_mode != MODE_IMM && ecode == ERR_NONE
                 && !reg_ok(i_opnd))
          ecode = ERR_RANGE;
        addr_d = word_addr(i_opnd, (i_mode == MODE_VECTOR) ? pos_d : '0);
        raddr  = addr_d;
        if (i_mode == MODE_VECTOR && ecode == ERR_RANGE && i_op > OP_DIV) ecode = ERR_NONE;
        state_d = ST_ADDR;
        if (ecode != ERR_NONE) begin
          err_d   = 1'b1;
          out_d   = {1'b0, ecode, halt_q, pc_q, 32'd0, 1'b0};
          state_d = ST_OUT;
        end
      end
      ST_ADDR: begin
        // rdata_q holds word at first address
        if (i_mode == MODE_INDIRECT) begin
          if (!reg_ok(rdata_q)) ecode = ERR_RANGE;
          addr_d = word_addr(rdata_q, '0);
        end
        raddr   = addr_d;
        state_d = ST_VAL;
        if (ecode != ERR_NONE && i_op <= OP_DIV) begin
          err_d   = 1'b1;
          out_d   = {1'b0, ecode, halt_q, pc_q, 32'd0, 1'b0};
          state_d = ST_OUT;
        end
      end
      ST_VAL: begin
        val_d   = (i_mode == MODE_IMM) ? i_opnd : rdata_q;
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        out_d = {1'b0, 3'(ERR_NONE), halt_q, nxt_line, 32'd0, 1'b0};
        pc_d  = nxt_line;
        state_d = ST_OUT;
        case (i_op)
          OP_READ:  begin we = 1'b1; wdata = i_tape; end
          OP_WRITE: out_d[32:0] = {val_q, 1'b1};
          OP_LOAD:  begin we = 1'b1; waddr = '0; wdata = val_q; end
          OP_STORE: begin we = 1'b1; wdata = acc_q; end
          OP_ADD:   begin we = 1'b1; waddr = '0; wdata = acc_q + val_q; end
          OP_SUB:   begin we = 1'b1; waddr = '0; wdata = acc_q - val_q; end
          OP_MUL:   begin we = 1'b1; waddr = '0; wdata = prod[WordW-1:0]; end
          OP_DIV: begin
            if (val_q == '0) ecode = ERR_DIVZERO;
            else begin
              div_req.start = 1'b1;
              pc_d    = pc_q;
              state_d = ST_DIV;
            end
          end
          OP_JUMP:  take = 1'b1;
          OP_JZERO: take = acc_q == '0;
          OP_JGTZ:  take = $signed(acc_q) > 0;
          OP_HALT: begin
            halt_d    = 1'b1;
            out_d[43] = 1'b1;
          end
          default: ;
        endcase
        if (take) begin
          if (!i_found) ecode = ERR_TAG;
          else if (32'(i_tgt) >= 32'(PROG_DEPTH)) ecode = ERR_RANGE;
          else begin
            pc_d        = i_tgt;
            out_d[42:33] = i_tgt;
          end
        end
        if (ecode != ERR_NONE) begin
          we      = 1'b0;
          err_d   = 1'b1;
          pc_d    = pc_q;
          out_d   = {1'b0, ecode, halt_q, pc_q, 32'd0, 1'b0};
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = div_rsp.quotient;
          pc_d    = nxt_line;
          out_d   = {1'b0, 3'(ERR_NONE), halt_q, nxt_line, 32'd0, 1'b0};
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (m_axis_tready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pc_q    <= '0;
      halt_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pc_q    <= pc_d;
      halt_q  <= halt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    acc_q  <= acc_d;
    val_q  <= val_d;
    addr_q <= addr_d;
    pos_q  <= pos_d;
    out_q  <= out_d;
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = state_q == ST_OUT;
  assign m_axis_tdata_o  = out_q;

endmodule

/* rtl/core/rme_div.sv */
module rme_div
  import rme_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [WordW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [WordW:0]   trial;
  logic [WordW-1:0] shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    shifted = {rem_q[WordW-2:0], quo_q[WordW-1]};
    trial   = {1'b0, shifted} - {1'b0, dvs_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend[WordW-1] ? (~req_i.dividend + 1'b1) : req_i.dividend;
      dvs_d  = req_i.divisor[WordW-1] ? (~req_i.divisor + 1'b1) : req_i.divisor;
      neg_d  = req_i.dividend[WordW-1] ^ req_i.divisor[WordW-1];
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q[WordW-1] || !trial[WordW]) begin
        rem_d = trial[WordW-1:0];
        quo_d = {quo_q[WordW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[WordW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(WordW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

/* rtl/core/rme_checker.sv */
module rme_checker
  import rme_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o
);

  ap_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o)) else $error("ready while result pending");

  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped");

  ap_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o) else $error("double accept");

  ap_tape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[46:44] == ERR_NONE)
    else $error("tape with error");

endmodule

bind ram_machine_execute rme_checker u_rme_checker (.*);
